### sv/tlwbc_pkg.sv
// ---------------------------------------------------------------------------
// Two-level write-back cache package
// Shared widths, cost register codes and the controller/datapath interface.
// ---------------------------------------------------------------------------
`default_nettype none

package tlwbc_pkg;

	localparam int ADDR_W    = 20;
	localparam int WORD_W    = 32;
	localparam int COST_W    = 16;
	localparam int TIME_W    = 32;
	localparam int CFG_IDX_W = 3;
	localparam int LANE_W    = 64;
	localparam int NUM_COSTS = 6;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_L1_RD  = 3'd0,
		CFG_L1_WR  = 3'd1,
		CFG_L2_RD  = 3'd2,
		CFG_L2_WR  = 3'd3,
		CFG_MEM_RD = 3'd4,
		CFG_MEM_WR = 3'd5
	} cost_sel_t;

	localparam logic [COST_W-1:0] COST_RST [NUM_COSTS] =
		'{16'd1, 16'd1, 16'd10, 16'd5, 16'd100, 16'd50};

	typedef enum logic [2:0] {
		CP_NONE,
		CP_L2_TO_MEM,
		CP_MEM_TO_L2,
		CP_L2_TO_BUF,
		CP_L1_TO_L2,
		CP_BUF_TO_L1
	} copy_op_t;

	typedef enum logic [1:0] {
		MW_NONE,
		MW_CLEAN,
		MW_DIRTY
	} meta_wr_t;

	typedef struct packed {
		logic      load;
		logic      clr;
		logic      l1_look;
		logic      l2_look_new;
		logic      l2_look_vic;
		meta_wr_t  l1_meta_wr;
		meta_wr_t  l2_meta_wr;
		copy_op_t  copy_op;
		logic      add_en;
		cost_sel_t add_sel;
		logic      word_rd0;
		logic      word_rd1;
		logic      word_cap;
		logic      word_wr0;
		logic      word_wr1;
		logic      out_load;
	} cmd_t;

	typedef struct packed {
		logic bad;
		logic req_wr;
		logic l1_hit;
		logic l1_vic_dirty;
		logic l2_hit;
		logic l2_vic_dirty;
		logic copy_done;
		logic clr_done;
		logic out_full;
		logic same_word;
	} status_t;

endpackage

`default_nettype wire

### sv/tlwbc_datapath.sv
// ---------------------------------------------------------------------------
// Two-level write-back cache datapath
// Tag and data stores of both levels, backing memory, block copy engine,
// cost registers, time counter and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module tlwbc_datapath #(
	parameter int L1_LINES    = 256,
	parameter int L2_LINES    = 512,
	parameter int BLOCK_BYTES = 64,
	parameter int MEM_BYTES   = 1048576
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_wr,
	input  wire logic [tlwbc_pkg::ADDR_W-1:0]   in_addr,
	input  wire logic [tlwbc_pkg::WORD_W-1:0]   in_wdata,
	input  wire logic                           cfg_wen,
	input  wire logic [tlwbc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [tlwbc_pkg::COST_W-1:0]   cfg_data,
	input  wire tlwbc_pkg::cmd_t                cmd,
	output tlwbc_pkg::status_t                  st,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [tlwbc_pkg::WORD_W-1:0]        out_rdata,
	output logic [tlwbc_pkg::TIME_W-1:0]        out_time,
	output logic                                out_bad
);
	import tlwbc_pkg::*;

	localparam int WPB   = BLOCK_BYTES / 8;
	localparam int WIW   = (WPB > 1) ? $clog2(WPB) : 1;
	localparam int OFFW  = $clog2(BLOCK_BYTES);
	localparam int BLKW  = ADDR_W - OFFW;
	localparam int L1I   = $clog2(L1_LINES);
	localparam int L2I   = $clog2(L2_LINES);
	localparam int L1TW  = BLKW - L1I;
	localparam int L2TW  = BLKW - L2I;
	localparam int L1DW  = $clog2(L1_LINES * WPB);
	localparam int L2DW  = $clog2(L2_LINES * WPB);
	localparam int MEMD  = MEM_BYTES / 8;
	localparam int MEMW  = $clog2(MEMD);

	logic                 req_wr_q;
	logic [ADDR_W-1:0]    req_addr_q;
	logic [WORD_W-1:0]    req_wdata_q;
	logic [OFFW-1:0]      off;
	logic [BLKW-1:0]      blk;
	logic [L1I-1:0]       l1_idx;
	logic [L1TW-1:0]      l1_tag;
	logic [WIW-1:0]       w0;
	logic [WIW-1:0]       w1;
	logic [OFFW-1:0]      off_end;
	logic                 bad;

	logic [L1TW+1:0]      l1_meta_mem [L1_LINES];
	logic [L1TW+1:0]      l1_meta_q;
	logic [BLKW-1:0]      vic_blk;
	logic [L2TW+1:0]      l2_meta_mem [L2_LINES];
	logic [L2TW+1:0]      l2_meta_q;
	logic [BLKW-1:0]      l2_blk_q;
	logic [BLKW-1:0]      l2_look_blk;
	logic [L2I-1:0]       l2_idx;
	logic [L2TW-1:0]      l2_tag;
	logic [BLKW-1:0]      l2_vic_blk;

	logic [LANE_W-1:0]    l1_data [L1_LINES * WPB];
	logic [LANE_W-1:0]    l2_data [L2_LINES * WPB];
	logic [LANE_W-1:0]    mem     [MEMD];
	logic [LANE_W-1:0]    buf_q   [WPB];
	logic [LANE_W-1:0]    l1_rd_q;
	logic [LANE_W-1:0]    l2_rd_q;
	logic [LANE_W-1:0]    mem_rd_q;
	logic [LANE_W-1:0]    pair_lo_q;
	logic [LANE_W-1:0]    pair_hi_q;
	logic [2*LANE_W-1:0]  pair;
	logic [2*LANE_W-1:0]  merged;
	logic [2*LANE_W-1:0]  wmask;
	logic [6:0]           bsh;
	logic [WORD_W-1:0]    rd_word;

	logic                 cp_act_q;
	logic [WIW:0]         cp_rcnt_q;
	logic                 cp_wv_s1;
	logic [WIW-1:0]       cp_wi_s1;
	logic                 cp_rd_go;
	logic                 cp_done;
	logic [WIW-1:0]       rd_wi;
	logic [WIW-1:0]       l1_rd_wi;
	logic [WIW-1:0]       l1_wr_wi;
	logic [L1DW-1:0]      l1_raddr;
	logic [L1DW-1:0]      l1_waddr;
	logic [L2DW-1:0]      l2_raddr;
	logic [L2DW-1:0]      l2_waddr;
	logic [MEMW-1:0]      mem_raddr;
	logic [MEMW-1:0]      mem_waddr;
	logic                 l1_we;
	logic                 l2_we;
	logic                 mem_we;
	logic [LANE_W-1:0]    l1_wdat;
	logic [LANE_W-1:0]    l2_wdat;
	logic [LANE_W-1:0]    mem_wdat;
	logic                 l1_mwe;
	logic                 l2_mwe;
	logic [L1I-1:0]       l1_maddr;
	logic [L2I-1:0]       l2_maddr;
	logic [L1TW+1:0]      l1_mdat;
	logic [L2TW+1:0]      l2_mdat;

	logic [MEMW-1:0]      clr_cnt_q;
	logic [COST_W-1:0]    cost_q [NUM_COSTS];
	logic [TIME_W-1:0]    time_q;
	cost_sel_t            cfg_sel;

	assign off     = req_addr_q[OFFW-1:0];
	assign blk     = req_addr_q[ADDR_W-1:OFFW];
	assign l1_idx  = blk[L1I-1:0];
	assign l1_tag  = blk[BLKW-1:L1I];
	assign off_end = off + OFFW'(3);
	assign w0      = WIW'(off >> 3);
	assign w1      = WIW'(off_end >> 3);
	assign bad     = (32'(req_addr_q) > 32'(MEM_BYTES - 4)) ||
	                 (32'(off) > 32'(BLOCK_BYTES - 4));

	assign vic_blk     = {l1_meta_q[L1TW-1:0], l1_idx};
	assign l2_look_blk = cmd.l2_look_vic ? vic_blk : blk;
	assign l2_idx      = l2_blk_q[L2I-1:0];
	assign l2_tag      = l2_blk_q[BLKW-1:L2I];
	assign l2_vic_blk  = {l2_meta_q[L2TW-1:0], l2_idx};

	assign pair    = {pair_hi_q, pair_lo_q};
	assign bsh     = {req_addr_q[2:0], 3'b000} + 7'd0;
	assign rd_word = WORD_W'(pair >> bsh);
	assign wmask   = {{(2*LANE_W-WORD_W){1'b0}}, {WORD_W{1'b1}}} << bsh;
	assign merged  = (pair & ~wmask) | ((2*LANE_W)'(req_wdata_q) << bsh);

	assign cp_rd_go = cp_act_q && (cp_rcnt_q != (WIW+1)'(WPB));
	assign cp_done  = cp_act_q && (cp_rcnt_q == (WIW+1)'(WPB)) && !cp_wv_s1;
	assign rd_wi    = cp_rcnt_q[WIW-1:0];
	assign l1_rd_wi = cmd.word_rd1 ? w1 : (cmd.word_rd0 ? w0 : rd_wi);
	assign l1_wr_wi = cmd.word_wr1 ? w1 : (cmd.word_wr0 ? w0 : cp_wi_s1);

	assign l1_raddr  = L1DW'(int'(l1_idx) * WPB + int'(l1_rd_wi));
	assign l1_waddr  = L1DW'(int'(l1_idx) * WPB + int'(l1_wr_wi));
	assign l2_raddr  = L2DW'(int'(l2_idx) * WPB + int'(rd_wi));
	assign l2_waddr  = L2DW'(int'(l2_idx) * WPB + int'(cp_wi_s1));
	assign mem_raddr = MEMW'(int'(l2_blk_q) * WPB + int'(rd_wi));
	assign mem_waddr = cmd.clr ? clr_cnt_q :
	                   MEMW'(int'(l2_vic_blk) * WPB + int'(cp_wi_s1));

	assign l1_we   = (cp_wv_s1 && cmd.copy_op == CP_BUF_TO_L1) || cmd.word_wr0 || cmd.word_wr1;
	assign l1_wdat = cmd.word_wr0 ? merged[LANE_W-1:0] :
	                 cmd.word_wr1 ? merged[2*LANE_W-1:LANE_W] : buf_q[cp_wi_s1];
	assign l2_we   = cp_wv_s1 && (cmd.copy_op == CP_MEM_TO_L2 || cmd.copy_op == CP_L1_TO_L2);
	assign l2_wdat = (cmd.copy_op == CP_MEM_TO_L2) ? mem_rd_q : l1_rd_q;
	assign mem_we  = cmd.clr || (cp_wv_s1 && cmd.copy_op == CP_L2_TO_MEM);
	assign mem_wdat = cmd.clr ? '0 : l2_rd_q;

	assign l1_mwe   = cmd.clr || (cmd.l1_meta_wr != MW_NONE);
	assign l1_maddr = cmd.clr ? clr_cnt_q[L1I-1:0] : l1_idx;
	assign l1_mdat  = cmd.clr ? '0 : {1'b1, cmd.l1_meta_wr == MW_DIRTY, l1_tag};
	assign l2_mwe   = cmd.clr || (cmd.l2_meta_wr != MW_NONE);
	assign l2_maddr = cmd.clr ? clr_cnt_q[L2I-1:0] : l2_idx;
	assign l2_mdat  = cmd.clr ? '0 : {1'b1, cmd.l2_meta_wr == MW_DIRTY, l2_tag};

	assign cfg_sel = cost_sel_t'(cfg_index);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_wr_q    <= in_wr;
			req_addr_q  <= in_addr;
			req_wdata_q <= in_wdata;
		end
		if (cmd.l1_look) begin
			l1_meta_q <= l1_meta_mem[l1_idx];
		end
		if (cmd.l2_look_new || cmd.l2_look_vic) begin
			l2_blk_q  <= l2_look_blk;
			l2_meta_q <= l2_meta_mem[l2_look_blk[L2I-1:0]];
		end
		if (l1_mwe) begin
			l1_meta_mem[l1_maddr] <= l1_mdat;
		end
		if (l2_mwe) begin
			l2_meta_mem[l2_maddr] <= l2_mdat;
		end
		l1_rd_q  <= l1_data[l1_raddr];
		l2_rd_q  <= l2_data[l2_raddr];
		mem_rd_q <= mem[mem_raddr];
		if (l1_we) begin
			l1_data[l1_waddr] <= l1_wdat;
		end
		if (l2_we) begin
			l2_data[l2_waddr] <= l2_wdat;
		end
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdat;
		end
		if (cp_wv_s1 && cmd.copy_op == CP_L2_TO_BUF) begin
			buf_q[cp_wi_s1] <= l2_rd_q;
		end
		if (cmd.word_rd1) begin
			pair_lo_q <= l1_rd_q;
		end
		if (cmd.word_cap) begin
			pair_hi_q <= l1_rd_q;
		end
		cp_wi_s1 <= rd_wi;
		if (cmd.out_load) begin
			out_rdata <= (bad || req_wr_q) ? '0 : rd_word;
			out_time  <= time_q;
			out_bad   <= bad;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cp_act_q  <= 1'b0;
			cp_rcnt_q <= '0;
			cp_wv_s1  <= 1'b0;
			clr_cnt_q <= '0;
			time_q    <= '0;
			out_valid <= 1'b0;
			cost_q    <= COST_RST;
		end else begin
			if (!cp_act_q) begin
				cp_wv_s1 <= 1'b0;
				if (cmd.copy_op != CP_NONE) begin
					cp_act_q  <= 1'b1;
					cp_rcnt_q <= '0;
				end
			end else begin
				cp_wv_s1 <= cp_rd_go;
				if (cp_rd_go) begin
					cp_rcnt_q <= cp_rcnt_q + 1'b1;
				end
				if (cp_done) begin
					cp_act_q <= 1'b0;
				end
			end
			if (cmd.clr) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (cmd.add_en) begin
				time_q <= time_q + TIME_W'(cost_q[cmd.add_sel]);
			end
			if (cmd.out_load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			if (cfg_wen) begin
				case (cfg_sel)
					CFG_L1_RD, CFG_L1_WR, CFG_L2_RD, CFG_L2_WR, CFG_MEM_RD, CFG_MEM_WR: begin
						cost_q[cfg_sel] <= cfg_data;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_comb begin
		st.bad          = bad;
		st.req_wr       = req_wr_q;
		st.l1_hit       = l1_meta_q[L1TW+1] && (l1_meta_q[L1TW-1:0] == l1_tag);
		st.l1_vic_dirty = l1_meta_q[L1TW+1] && l1_meta_q[L1TW];
		st.l2_hit       = l2_meta_q[L2TW+1] && (l2_meta_q[L2TW-1:0] == l2_tag);
		st.l2_vic_dirty = l2_meta_q[L2TW+1] && l2_meta_q[L2TW];
		st.copy_done    = cp_done;
		st.clr_done     = (clr_cnt_q == MEMW'(MEMD - 1));
		st.out_full     = out_valid;
		st.same_word    = (w0 == w1);
	end

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !out_valid) else $error("result overwritten");
	a_word_vs_copy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.word_wr0 || cmd.word_wr1) |-> !cp_wv_s1) else $error("L1 write port clash");
	a_copy_wv: assert property (@(posedge clk) disable iff (!arst_n)
		cp_wv_s1 |-> cp_act_q) else $error("copy write outside transfer");
	a_clr_excl: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr |-> (cmd.copy_op == CP_NONE && !cmd.load)) else $error("clear overlaps access");

endmodule

`default_nettype wire

### sv/tlwbc_ctrl.sv
// ---------------------------------------------------------------------------
// Two-level write-back cache controller
// Sequences lookup, victim write-back, block fills and the word access.
// ---------------------------------------------------------------------------
`default_nettype none

module tlwbc_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire tlwbc_pkg::status_t  st,
	output tlwbc_pkg::cmd_t          cmd
);
	import tlwbc_pkg::*;

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_L1_LOOK,
		S_L1_CHECK,
		S_L2_LOOK_NEW,
		S_L2_LOOK_VIC,
		S_L2_CHECK,
		S_L2_WB,
		S_L2_FILL,
		S_L2_TO_BUF,
		S_L1_TO_L2,
		S_BUF_TO_L1,
		S_WORD_RD0,
		S_WORD_RD1,
		S_WORD_CAP,
		S_WORD_WR0,
		S_WORD_WR1,
		S_FINISH
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   vic_q;
	logic   vic_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		vic_d   = vic_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (st.clr_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				cmd.load = in_valid;
				if (in_valid) begin
					state_d = S_L1_LOOK;
				end
			end
			S_L1_LOOK: begin
				cmd.l1_look = 1'b1;
				state_d     = S_L1_CHECK;
			end
			S_L1_CHECK: begin
				vic_d = 1'b0;
				if (st.bad) begin
					state_d = S_FINISH;
				end else if (st.l1_hit) begin
					state_d = S_WORD_RD0;
				end else begin
					state_d = S_L2_LOOK_NEW;
				end
			end
			S_L2_LOOK_NEW: begin
				cmd.l2_look_new = 1'b1;
				state_d         = S_L2_CHECK;
			end
			S_L2_LOOK_VIC: begin
				cmd.l2_look_vic = 1'b1;
				state_d         = S_L2_CHECK;
			end
			S_L2_CHECK: begin
				if (st.l2_hit) begin
					state_d = vic_q ? S_L1_TO_L2 : S_L2_TO_BUF;
				end else begin
					cmd.add_en  = 1'b1;
					cmd.add_sel = CFG_MEM_RD;
					if (st.l2_vic_dirty) begin
						state_d = S_L2_WB;
					end else begin
						state_d = vic_q ? S_L1_TO_L2 : S_L2_FILL;
					end
				end
			end
			S_L2_WB: begin
				cmd.copy_op = CP_L2_TO_MEM;
				if (st.copy_done) begin
					cmd.add_en  = 1'b1;
					cmd.add_sel = CFG_MEM_WR;
					state_d     = vic_q ? S_L1_TO_L2 : S_L2_FILL;
				end
			end
			S_L2_FILL: begin
				cmd.copy_op = CP_MEM_TO_L2;
				if (st.copy_done) begin
					cmd.l2_meta_wr = MW_CLEAN;
					state_d        = S_L2_TO_BUF;
				end
			end
			S_L2_TO_BUF: begin
				cmd.copy_op = CP_L2_TO_BUF;
				if (st.copy_done) begin
					cmd.add_en  = 1'b1;
					cmd.add_sel = CFG_L2_RD;
					if (st.l1_vic_dirty) begin
						vic_d   = 1'b1;
						state_d = S_L2_LOOK_VIC;
					end else begin
						state_d = S_BUF_TO_L1;
					end
				end
			end
			S_L1_TO_L2: begin
				cmd.copy_op = CP_L1_TO_L2;
				if (st.copy_done) begin
					cmd.add_en     = 1'b1;
					cmd.add_sel    = CFG_L2_WR;
					cmd.l2_meta_wr = MW_DIRTY;
					state_d        = S_BUF_TO_L1;
				end
			end
			S_BUF_TO_L1: begin
				cmd.copy_op = CP_BUF_TO_L1;
				if (st.copy_done) begin
					cmd.l1_meta_wr = MW_CLEAN;
					state_d        = S_WORD_RD0;
				end
			end
			S_WORD_RD0: begin
				cmd.word_rd0 = 1'b1;
				state_d      = S_WORD_RD1;
			end
			S_WORD_RD1: begin
				cmd.word_rd1 = 1'b1;
				state_d      = S_WORD_CAP;
			end
			S_WORD_CAP: begin
				cmd.word_cap = 1'b1;
				if (st.req_wr) begin
					state_d = S_WORD_WR0;
				end else begin
					cmd.add_en  = 1'b1;
					cmd.add_sel = CFG_L1_RD;
					state_d     = S_FINISH;
				end
			end
			S_WORD_WR0: begin
				cmd.word_wr0 = 1'b1;
				if (st.same_word) begin
					cmd.add_en     = 1'b1;
					cmd.add_sel    = CFG_L1_WR;
					cmd.l1_meta_wr = MW_DIRTY;
					state_d        = S_FINISH;
				end else begin
					state_d = S_WORD_WR1;
				end
			end
			S_WORD_WR1: begin
				cmd.word_wr1   = 1'b1;
				cmd.add_en     = 1'b1;
				cmd.add_sel    = CFG_L1_WR;
				cmd.l1_meta_wr = MW_DIRTY;
				state_d        = S_FINISH;
			end
			S_FINISH: begin
				if (!st.out_full) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			vic_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			vic_q   <= vic_d;
		end
	end

	a_accept_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready) else $error("accepted word not taken up");
	a_one_copy: assert property (@(posedge clk) disable iff (!arst_n)
		st.copy_done |-> (cmd.copy_op != CP_NONE)) else $error("stray copy completion");
	a_meta_once: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.l1_meta_wr != MW_NONE) |=> (cmd.l1_meta_wr == MW_NONE))
		else $error("repeated L1 tag write");

endmodule

`default_nettype wire

### sv/two_level_writeback_cache.sv
// A hit reads the word from L1, and a write hit writes it back, with one more write step
// when the word straddles two 64-bit lanes; a bad address skips the access.
// One access is served at a time; s_tready returns as the result is loaded into the output register.
// A miss adds an L2 lookup for each block sought in L2 and a block transfer for each block moved.
// After reset the block clears tags and backing memory with s_tready low;
// configuration writes are taken throughout.
// ---------------------------------------------------------------------------
// Two-level write-back cache
// Direct-mapped write-back L1 and L2 in front of a backing memory, with a
// configurable access-time counter.
// ---------------------------------------------------------------------------
`default_nettype none

module two_level_writeback_cache #(
	parameter int L1_LINES    = 256,
	parameter int L2_LINES    = 512,
	parameter int BLOCK_BYTES = 64,
	parameter int MEM_BYTES   = 1048576
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [55:0] s_tdata,   // address[19:0], write_data[51:20], zero pad
	input  wire logic        s_tuser,   // func
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata,   // read_data[31:0], elapsed_time[63:32]
	output logic             m_tuser,   // bad_address
	input  wire logic        cfg_wen,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);
	import tlwbc_pkg::*;

	cmd_t              cmd;
	status_t           st;
	logic [WORD_W-1:0] rdata;
	logic [TIME_W-1:0] etime;

	tlwbc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	tlwbc_datapath #(
		.L1_LINES    (L1_LINES),
		.L2_LINES    (L2_LINES),
		.BLOCK_BYTES (BLOCK_BYTES),
		.MEM_BYTES   (MEM_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_wr     (s_tuser),
		.in_addr   (s_tdata[19:0]),
		.in_wdata  (s_tdata[51:20]),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.st        (st),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_rdata (rdata),
		.out_time  (etime),
		.out_bad   (m_tuser)
	);

	assign m_tdata = {etime, rdata};

endmodule

`default_nettype wire

### tb/two_level_writeback_cache_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Two-level write-back cache testbench
// Drives directed and random word reads and writes through the stream port,
// keeps its own model of both cache levels, the backing memory and the time
// counter, and checks every returned word against it across several cost
// settings.
// ---------------------------------------------------------------------------
`default_nettype none

module two_level_writeback_cache_tb;

	import tlwbc_pkg::*;

	localparam int LIMIT = 1000000;
	localparam int BLK   = 64;
	localparam int L1N   = 256;
	localparam int L2N   = 512;
	localparam int MEMB  = 1048576;

	typedef struct {
		bit          wr;
		logic [19:0] addr;
		logic [31:0] data;
	} access_t;

	typedef struct {
		logic [31:0] rdata;
		logic [31:0] etime;
		logic        bad;
	} reply_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [55:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;
	logic        m_tuser;
	logic        cfg_wen;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	access_t pending_q[$];
	reply_t  reply_q[$];
	int      fail_count;
	int      quiet_cycles;
	int      gap_left;
	int      stall_left;
	bit      word_taken;
	bit      idle_en;

	logic [15:0] cost_m [NUM_COSTS];
	logic [31:0] time_m;
	bit          l1_val [L1N];
	bit          l1_drt [L1N];
	logic [5:0]  l1_tg  [L1N];
	logic [7:0]  l1_byt [L1N*BLK];
	bit          l2_val [L2N];
	bit          l2_drt [L2N];
	logic [4:0]  l2_tg  [L2N];
	logic [7:0]  l2_byt [L2N*BLK];
	logic [7:0]  mem_byt [int];
	logic [7:0]  xfer_buf [BLK];
	logic [5:0]  tag_pool [4];
	logic [7:0]  idx_pool [4];

	two_level_writeback_cache dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic logic [7:0] mem_rd(int unsigned a);
		if (a < MEMB && mem_byt.exists(a))
			return mem_byt[a];
		return 8'h00;
	endfunction

	// Block transfer between L1 and L2 through xfer_buf; an L2 miss writes back a dirty victim and refills.
	function automatic void l2_block_xfer(int unsigned base, bit wr);
		int unsigned blk, idx, tg, old_base;
		logic [7:0] fresh [BLK];
		blk = base / BLK;
		idx = blk % L2N;
		tg  = blk / L2N;
		if (!l2_val[idx] || l2_tg[idx] != tg) begin
			for (int i = 0; i < BLK; i++)
				fresh[i] = mem_rd(blk * BLK + i);
			time_m += cost_m[CFG_MEM_RD];
			if (l2_val[idx] && l2_drt[idx]) begin
				old_base = (l2_tg[idx] * L2N + idx) * BLK;
				for (int i = 0; i < BLK; i++)
					if (old_base + i < MEMB)
						mem_byt[old_base + i] = l2_byt[idx*BLK + i];
				time_m += cost_m[CFG_MEM_WR];
			end
			for (int i = 0; i < BLK; i++)
				l2_byt[idx*BLK + i] = fresh[i];
			l2_val[idx] = 1'b1;
			l2_tg[idx]  = tg;
			l2_drt[idx] = 1'b0;
		end
		if (wr) begin
			for (int i = 0; i < BLK; i++)
				l2_byt[idx*BLK + i] = xfer_buf[i];
			l2_drt[idx] = 1'b1;
			time_m += cost_m[CFG_L2_WR];
		end else begin
			for (int i = 0; i < BLK; i++)
				xfer_buf[i] = l2_byt[idx*BLK + i];
			time_m += cost_m[CFG_L2_RD];
		end
	endfunction

	function automatic reply_t cache_access(access_t a);
		reply_t r;
		int unsigned off, blk, idx, tg;
		logic [7:0] fresh [BLK];
		off = a.addr % BLK;
		r.rdata = 32'd0;
		r.bad = 1'b0;
		if (a.addr > MEMB - 4 || off + 4 > BLK) begin
			r.bad = 1'b1;
			r.etime = time_m;
			return r;
		end
		blk = a.addr / BLK;
		idx = blk % L1N;
		tg  = blk / L1N;
		if (!l1_val[idx] || l1_tg[idx] != tg) begin
			l2_block_xfer(blk * BLK, 1'b0);
			for (int i = 0; i < BLK; i++)
				fresh[i] = xfer_buf[i];
			if (l1_val[idx] && l1_drt[idx]) begin
				for (int i = 0; i < BLK; i++)
					xfer_buf[i] = l1_byt[idx*BLK + i];
				l2_block_xfer((l1_tg[idx] * L1N + idx) * BLK, 1'b1);
			end
			for (int i = 0; i < BLK; i++)
				l1_byt[idx*BLK + i] = fresh[i];
			l1_val[idx] = 1'b1;
			l1_tg[idx]  = tg;
			l1_drt[idx] = 1'b0;
		end
		if (a.wr) begin
			for (int i = 0; i < 4; i++)
				l1_byt[idx*BLK + off + i] = a.data[8*i +: 8];
			l1_drt[idx] = 1'b1;
			time_m += cost_m[CFG_L1_WR];
		end else begin
			for (int i = 0; i < 4; i++)
				r.rdata[8*i +: 8] = l1_byt[idx*BLK + off + i];
			time_m += cost_m[CFG_L1_RD];
		end
		r.etime = time_m;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch on %s: got %h, expected %h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!idle_en || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Monitor: predict on each accepted input word, check each accepted result word.
	always @(posedge clk) begin
		access_t a;
		reply_t  want;
		word_taken = 1'b0;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				a.wr   = s_tuser;
				a.addr = s_tdata[19:0];
				a.data = s_tdata[51:20];
				reply_q.push_back(cache_access(a));
				word_taken = 1'b1;
			end
			if (m_tvalid && m_tready) begin
				if (reply_q.size() == 0) begin
					report_mismatch("unexpected result", m_tdata[31:0], 32'd0);
				end else begin
					want = reply_q.pop_front();
					if (m_tdata[31:0] !== want.rdata)
						report_mismatch("read_data", m_tdata[31:0], want.rdata);
					if (m_tdata[63:32] !== want.etime)
						report_mismatch("elapsed_time", m_tdata[63:32], want.etime);
					if (m_tuser !== want.bad)
						report_mismatch("bad_address", {31'd0, m_tuser}, {31'd0, want.bad});
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= LIMIT) begin
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	// Driver for the input stream and the result back-pressure.
	always @(negedge clk) begin
		access_t a;
		logic    nxt_valid;
		nxt_valid = s_tvalid;
		if (arst_n) begin
			if (s_tvalid && word_taken) begin
				nxt_valid = 1'b0;
				gap_left = pick_gap();
			end
			if (!nxt_valid) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_q.size() > 0) begin
					a = pending_q.pop_front();
					s_tdata <= {4'd0, a.data, a.addr};
					s_tuser <= a.wr;
					nxt_valid = 1'b1;
				end
			end
			s_tvalid <= nxt_valid;
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				stall_left = pick_gap();
				m_tready <= (stall_left == 0);
			end
		end
	end

	task automatic add_access(bit wr, logic [19:0] addr, logic [31:0] data);
		access_t a;
		a.wr = wr;
		a.addr = addr;
		a.data = data;
		pending_q.push_back(a);
	endtask

	task automatic write_cost(logic [2:0] idx, logic [15:0] val);
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx < NUM_COSTS)
			cost_m[idx] = val;
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic drain();
		while (pending_q.size() > 0 || s_tvalid || reply_q.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic logic [19:0] rand_address();
		int r;
		logic [19:0] a;
		r = $urandom_range(0, 99);
		a = 20'($urandom);
		if (r < 8) begin
			a[5:0] = 6'($urandom_range(61, 63));
			return a;
		end
		if (r < 75)
			a[19:14] = tag_pool[$urandom_range(0, 3)];
		if ($urandom_range(0, 1))
			a[13:6] = idx_pool[$urandom_range(0, 3)];
		a[5:0] = 6'($urandom_range(0, 60));
		return a;
	endfunction

	task automatic random_phase(int count);
		for (int i = 0; i < 4; i++) begin
			tag_pool[i] = 6'($urandom);
			idx_pool[i] = 8'($urandom);
		end
		idx_pool[0] = 8'h00;
		idx_pool[1] = 8'hFF;
		for (int i = 0; i < count; i++)
			add_access(1'($urandom_range(0, 1)), rand_address(), $urandom);
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		m_tready = 1'b0;
		cfg_wen = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		fail_count = 0;
		quiet_cycles = 0;
		gap_left = 0;
		stall_left = 0;
		word_taken = 1'b0;
		idle_en = 1'b1;
		time_m = '0;
		for (int i = 0; i < NUM_COSTS; i++)
			cost_m[i] = COST_RST[i];
		for (int i = 0; i < L1N; i++) begin
			l1_val[i] = 1'b0; l1_drt[i] = 1'b0; l1_tg[i] = '0;
		end
		for (int i = 0; i < L2N; i++) begin
			l2_val[i] = 1'b0; l2_drt[i] = 1'b0; l2_tg[i] = '0;
		end
		for (int i = 0; i < L1N*BLK; i++)
			l1_byt[i] = 8'h00;
		for (int i = 0; i < L2N*BLK; i++)
			l2_byt[i] = 8'h00;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part with the reset costs: extremes, bad addresses and evictions.
		add_access(1'b0, 20'h00000, 32'h0);
		add_access(1'b1, 20'h00000, 32'hFFFFFFFF);
		add_access(1'b0, 20'h00000, 32'h0);
		add_access(1'b1, 20'hFFFFC, 32'hA5A5_5A5A);
		add_access(1'b0, 20'hFFFFC, 32'h0);
		add_access(1'b0, 20'hFFFFD, 32'h0);
		add_access(1'b1, 20'hFFFFF, 32'h1234_5678);
		add_access(1'b0, 20'h0003D, 32'h0);
		add_access(1'b1, 20'h0003C, 32'h0BAD_F00D);
		add_access(1'b1, 20'h00033, 32'hDEAD_BEEF);
		add_access(1'b0, 20'h04000, 32'h0);
		add_access(1'b1, 20'h04004, 32'h1111_2222);
		add_access(1'b0, 20'h08000, 32'h0);
		add_access(1'b1, 20'h08010, 32'h3333_4444);
		add_access(1'b0, 20'h10000, 32'h0);
		add_access(1'b0, 20'h00000, 32'h0);
		add_access(1'b0, 20'h0003C, 32'h0);
		add_access(1'b0, 20'h04004, 32'h0);
		add_access(1'b0, 20'h08010, 32'h0);
		add_access(1'b0, 20'h00033, 32'h0);
		add_access(1'b1, 20'h7FFC0, 32'h0000_0001);
		add_access(1'b0, 20'hFFFC0, 32'h0);
		add_access(1'b0, 20'h7FFC0, 32'h0);
		drain();

		random_phase(150);
		for (int i = 0; i < NUM_COSTS; i++)
			write_cost(i[2:0], 16'h0000);
		idle_en = 1'b0;
		random_phase(120);
		idle_en = 1'b1;
		for (int i = 0; i < NUM_COSTS; i++)
			write_cost(i[2:0], 16'hFFFF);
		random_phase(150);
		for (int i = 0; i < NUM_COSTS; i++)
			write_cost(i[2:0], 16'($urandom));
		write_cost(3'(NUM_COSTS), 16'h1234);
		write_cost(3'(NUM_COSTS + 1), 16'hFFFF);
		random_phase(150);
		write_cost(CFG_L1_RD, 16'h0000);
		write_cost(CFG_MEM_RD, 16'hFFFF);
		write_cost(CFG_L2_WR, 16'h8001);
		idle_en = 1'b0;
		random_phase(120);
		idle_en = 1'b1;
		for (int i = 0; i < NUM_COSTS; i++)
			write_cost(i[2:0], COST_RST[i]);
		random_phase(140);

		if (fail_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

`default_nettype wire
